// ----- rtl/obvi_pkg.sv -----
// obvi_pkg: types, constants and sequencer states for the order book VWAP block.
// No dependencies; used by order_book_vwap_imbalance_top.
`default_nettype none
package obvi_pkg;

  localparam int MAX_LEVELS = 64;
  localparam int PRICE_BITS = 24;
  localparam int LVL_W      = $clog2(MAX_LEVELS + 1);

  localparam int FLD_W  = 24;
  localparam int PROD_W = 2 * FLD_W;
  localparam int WSUM_W = 54;
  localparam int VSUM_W = 30;
  localparam int MID_W  = 40;
  localparam int IMB_W  = 16;
  localparam int SLIP_W = 32;

  // shared restoring divider
  localparam int DVD_W     = 70;
  localparam int DSR_W     = 40;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [IMB_W-1:0]  IMB_MAX  = 16'h7fff;
  localparam logic [SLIP_W-1:0] SLIP_MAX = 32'hffff_ffff;

  typedef struct packed {
    logic [FLD_W-1:0] bid_price;
    logic [FLD_W-1:0] bid_qty;
    logic [FLD_W-1:0] ask_price;
    logic [FLD_W-1:0] ask_qty;
    logic             last_level;
  } in_t;

  typedef struct packed {
    logic [MID_W-1:0]         weighted_mid;
    logic [FLD_W-1:0]         spread;
    logic signed [IMB_W-1:0]  imbalance;
    logic [SLIP_W-1:0]        slippage;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_BID,
    S_ASK,
    S_IMB,
    S_SLIP,
    S_MUL
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/order_book_vwap_imbalance_top.sv -----
// Order book VWAP, mid, spread, imbalance and slippage.
// A last level runs S_PREP, four divisions on the shared bit-serial divider
// (S_BID, S_ASK, S_IMB, S_SLIP) and S_MUL, then the one-cycle result strobe.
// Throughput: one level per cycle while accumulating; busy is high during the tail.
// Reset (rst_n, synchronous) clears sums, level count and best prices; the receiver
// cannot stall, so out_valid is a plain one-cycle strobe.
// Depends on obvi_pkg.
`default_nettype none
module order_book_vwap_imbalance_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire obvi_pkg::in_t in_data,
  output logic               out_valid,
  output obvi_pkg::out_t     out_data
);

  localparam logic [obvi_pkg::FLD_W-1:0] PMASK =
    obvi_pkg::FLD_W'((64'd1 << obvi_pkg::PRICE_BITS) - 64'd1);

  obvi_pkg::state_t state_r, state_nxt;

  logic [obvi_pkg::WSUM_W-1:0] bid_ws_r, ask_ws_r;
  logic [obvi_pkg::VSUM_W-1:0] bid_vs_r, ask_vs_r;
  logic [obvi_pkg::FLD_W-1:0]  best_bid_r, best_ask_r;
  logic [obvi_pkg::LVL_W-1:0]  levels_r;

  logic [obvi_pkg::DVD_W-1:0]  dvd_r;
  logic [obvi_pkg::DSR_W:0]    rem_r;
  logic [obvi_pkg::DSR_W-1:0]  dsr_r;
  logic [obvi_pkg::CNT_W-1:0]  cnt_r;

  logic [obvi_pkg::MID_W-1:0]        bid_vwap_r, mid_r;
  logic signed [obvi_pkg::IMB_W-1:0] imb_r;
  logic [obvi_pkg::SLIP_W-1:0]       ratio_r;
  logic                              out_valid_r;
  obvi_pkg::out_t                    out_r;

  logic                              accept, acc_en, div_last;
  logic [obvi_pkg::FLD_W-1:0]        bp, ap, spread;
  logic [obvi_pkg::DSR_W:0]          trial;
  logic                              ge;
  logic [obvi_pkg::DVD_W-1:0]        quo;
  logic [obvi_pkg::MID_W-1:0]        ask_avg;
  logic [obvi_pkg::MID_W:0]          vwap_sum;
  logic [obvi_pkg::VSUM_W:0]         total, diff;
  logic                              imb_neg;
  logic [obvi_pkg::IMB_W-1:0]        mag;
  logic [16:0]                       imb_abs;
  logic [48:0]                       prod;
  logic [33:0]                       slip_full;

  assign accept = start && !busy;
  assign acc_en = accept && (levels_r < obvi_pkg::LVL_W'(obvi_pkg::MAX_LEVELS));
  assign bp     = in_data.bid_price & PMASK;
  assign ap     = in_data.ask_price & PMASK;
  assign spread = (best_ask_r >= best_bid_r) ? best_ask_r - best_bid_r
                                             : best_bid_r - best_ask_r;

  // one restoring divider step
  assign trial    = {rem_r[obvi_pkg::DSR_W-1:0], dvd_r[obvi_pkg::DVD_W-1]};
  assign ge       = trial >= {1'b0, dsr_r};
  assign quo      = {dvd_r[obvi_pkg::DVD_W-2:0], ge};
  assign div_last = cnt_r == obvi_pkg::CNT_W'(obvi_pkg::DIV_STEPS - 1);

  assign ask_avg  = (ask_vs_r == '0) ? {best_ask_r, 16'd0} : quo[obvi_pkg::MID_W-1:0];
  assign vwap_sum = {1'b0, bid_vwap_r} + {1'b0, ask_avg};
  assign total    = {1'b0, bid_vs_r} + {1'b0, ask_vs_r};
  assign imb_neg  = ask_vs_r > bid_vs_r;
  assign diff     = imb_neg ? {1'b0, ask_vs_r - bid_vs_r} : {1'b0, bid_vs_r - ask_vs_r};
  assign mag      = quo[obvi_pkg::IMB_W-1:0];

  assign imb_abs   = imb_r[obvi_pkg::IMB_W-1] ? 17'(~{imb_r[15], imb_r} + 17'd1)
                                              : {1'b0, imb_r};
  assign prod      = {17'd0, ratio_r} * {32'd0, 17'd32768 + imb_abs};
  assign slip_full = prod[48:15];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      obvi_pkg::S_IDLE: if (accept && in_data.last_level) state_nxt = obvi_pkg::S_PREP;
      obvi_pkg::S_PREP: state_nxt = obvi_pkg::S_BID;
      obvi_pkg::S_BID:  if (div_last) state_nxt = obvi_pkg::S_ASK;
      obvi_pkg::S_ASK:  if (div_last) state_nxt = obvi_pkg::S_IMB;
      obvi_pkg::S_IMB:  if (div_last) state_nxt = obvi_pkg::S_SLIP;
      obvi_pkg::S_SLIP: if (div_last) state_nxt = obvi_pkg::S_MUL;
      obvi_pkg::S_MUL:  state_nxt = obvi_pkg::S_IDLE;
      default:          state_nxt = obvi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy      = state_r != obvi_pkg::S_IDLE;
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= obvi_pkg::S_IDLE;
      bid_ws_r    <= '0;
      ask_ws_r    <= '0;
      bid_vs_r    <= '0;
      ask_vs_r    <= '0;
      best_bid_r  <= '0;
      best_ask_r  <= '0;
      levels_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (acc_en) begin
        if (levels_r == '0) begin
          best_bid_r <= bp;
          best_ask_r <= ap;
        end
        bid_ws_r <= bid_ws_r + obvi_pkg::WSUM_W'(bp * in_data.bid_qty);
        ask_ws_r <= ask_ws_r + obvi_pkg::WSUM_W'(ap * in_data.ask_qty);
        bid_vs_r <= bid_vs_r + obvi_pkg::VSUM_W'(in_data.bid_qty);
        ask_vs_r <= ask_vs_r + obvi_pkg::VSUM_W'(in_data.ask_qty);
        levels_r <= levels_r + obvi_pkg::LVL_W'(1);
      end
      if (state_r == obvi_pkg::S_PREP || (state_r != obvi_pkg::S_IDLE && div_last)) begin
        cnt_r <= '0;
      end else if (state_r != obvi_pkg::S_IDLE) begin
        cnt_r <= cnt_r + obvi_pkg::CNT_W'(1);
      end
      if (state_r == obvi_pkg::S_MUL) begin
        out_valid_r <= 1'b1;
        bid_ws_r    <= '0;
        ask_ws_r    <= '0;
        bid_vs_r    <= '0;
        ask_vs_r    <= '0;
        levels_r    <= '0;
      end
    end
  end

  // divider operands and result datapath
  always_ff @(posedge clk) begin
    case (state_r)
      obvi_pkg::S_PREP: begin
        dvd_r <= {bid_ws_r, 16'd0};
        dsr_r <= obvi_pkg::DSR_W'(bid_vs_r);
        rem_r <= '0;
      end
      obvi_pkg::S_BID, obvi_pkg::S_ASK, obvi_pkg::S_IMB, obvi_pkg::S_SLIP: begin
        if (!div_last) begin
          dvd_r <= quo;
          rem_r <= ge ? trial - {1'b0, dsr_r} : trial;
        end else begin
          rem_r <= '0;
          case (state_r)
            obvi_pkg::S_BID: begin
              bid_vwap_r <= (bid_vs_r == '0) ? {best_bid_r, 16'd0}
                                             : quo[obvi_pkg::MID_W-1:0];
              dvd_r <= {ask_ws_r, 16'd0};
              dsr_r <= obvi_pkg::DSR_W'(ask_vs_r);
            end
            obvi_pkg::S_ASK: begin
              mid_r <= vwap_sum[obvi_pkg::MID_W:1];
              dvd_r <= obvi_pkg::DVD_W'({diff, 15'd0});
              dsr_r <= obvi_pkg::DSR_W'(total);
            end
            obvi_pkg::S_IMB: begin
              if (total == '0) begin
                imb_r <= '0;
              end else if (imb_neg) begin
                imb_r <= -$signed(mag);
              end else begin
                imb_r <= (mag > obvi_pkg::IMB_MAX) ? obvi_pkg::IMB_MAX : mag;
              end
              dvd_r <= obvi_pkg::DVD_W'({spread, 32'd0});
              dsr_r <= mid_r;
            end
            default: begin
              // spread at or above mid would give a quotient of 2^32 or more
              ratio_r <= ({16'd0, spread} >= mid_r) ? obvi_pkg::SLIP_MAX
                                                   : quo[obvi_pkg::SLIP_W-1:0];
            end
          endcase
        end
      end
      obvi_pkg::S_MUL: begin
        out_r.weighted_mid <= mid_r;
        out_r.spread       <= spread;
        out_r.imbalance    <= imb_r;
        if (mid_r == '0) begin
          out_r.slippage <= '0;
        end else if (slip_full[33:32] != 2'd0) begin
          out_r.slippage <= obvi_pkg::SLIP_MAX;
        end else begin
          out_r.slippage <= slip_full[31:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
